@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define DLVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Check that cons holds in the same cycle as ante.
`define DLVS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

@@ rtl/dlvs_pkg.sv @@
// Types, constants and register codes of the directional light vertex shader.
package dlvs_pkg;

  localparam int MAX_LIGHTS = 8;
  localparam int LIGHT_W    = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CNT_W      = $clog2(MAX_LIGHTS + 1);

  localparam int T_W   = 25;  // transformed normal component, Q10.14
  localparam int L_W   = 49;  // squared length, 28 fraction bits
  localparam int RES_W = 50;  // root search register
  localparam int R_W   = 25;  // integer root
  localparam int REM_W = 26;  // divider remainder
  localparam int Q_W   = 15;  // quotient bits
  localparam int U_W   = 16;  // unit normal component, Q1.14
  localparam int DOT_W = 32;  // dot product, 28 fraction bits
  localparam int SUM_W = 48;  // color accumulator, 28 fraction bits
  localparam int M_W   = 32;  // multiplier operand
  localparam int P_W   = 64;  // multiplier product

  localparam logic [L_W-1:0] LEN_SQ_MIN = L_W'(268);
  localparam logic [Q_W-1:0] ONE_Q14    = Q_W'(16384);
  localparam logic [4:0]     SQRT_TOP   = 5'd24;
  localparam logic [4:0]     DIV_TOP    = 5'd14;

  typedef enum logic [2:0] {
    REG_ROW0    = 3'd0,
    REG_ROW1    = 3'd1,
    REG_ROW2    = 3'd2,
    REG_AMBIENT = 3'd3,
    REG_ACTIVE  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    MOP_MAT = 2'd0,
    MOP_SQ  = 2'd1,
    MOP_DOT = 2'd2,
    MOP_COL = 2'd3
  } mop_e;

  typedef struct packed {
    logic [2:0][47:0] mat;
    logic [47:0]      ambient;
    logic [3:0]       active;
  } cfg_t;

  typedef struct packed {
    logic               mul_en;
    logic               acc_en;
    mop_e               op;
    logic [1:0]         row;
    logic [1:0]         col;
    logic [4:0]         step;
    logic               sqrt_init;
    logic               sqrt_step;
    logic               div_init;
    logic               div_step;
    logic               copy_t;
    logic               dot_clr;
    logic               out_load;
    logic [LIGHT_W-1:0] light;
  } cmd_t;

  typedef struct packed {
    logic len_big;
    logic dot_pos;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/directional_light_vertex_shade.sv @@
// Load request: no result; the next request may follow at once.
// Shade request: steps the shared multiplier, root and divider, then each active light;
//   a normal too short to normalize skips root and divider, a light facing away its color.
// A new request is taken while the previous result waits in the output register.
// Reset (rst_ni low, asynchronous) clears control and loads the identity matrix;
//   light slots hold no value until loaded.
module directional_light_vertex_shade (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [7:0]  normal_x_i,
  input  logic signed [7:0]  normal_y_i,
  input  logic signed [7:0]  normal_z_i,
  input  logic               last_normal_i,
  input  logic [2:0]         light_slot_i,
  input  logic signed [15:0] light_dir_x_i,
  input  logic signed [15:0] light_dir_y_i,
  input  logic signed [15:0] light_dir_z_i,
  input  logic [11:0]        light_red_i,
  input  logic [11:0]        light_green_i,
  input  logic [11:0]        light_blue_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        red_o,
  output logic [15:0]        green_o,
  output logic [15:0]        blue_o,
  output logic               batch_end_o
);
  import dlvs_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  dlvs_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  dlvs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i (in_fire),
    .action_i,
    .active_i  (cfg.active),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .in_ready_o
  );

  dlvs_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_i     (cfg),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_fire_i (in_fire),
    .action_i, .normal_x_i, .normal_y_i, .normal_z_i, .last_normal_i,
    .light_slot_i, .light_dir_x_i, .light_dir_y_i, .light_dir_z_i,
    .light_red_i, .light_green_i, .light_blue_i,
    .out_valid_o, .out_ready_i, .red_o, .green_o, .blue_o, .batch_end_o
  );

endmodule

@@ rtl/dlvs_regs.sv @@
// Configuration register file behind the APB-style port.
module dlvs_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output dlvs_pkg::cfg_t       cfg_o
);
  import dlvs_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Decode the write request
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ROW0:    cfg_d.mat[0]  = pwdata[47:0];
        REG_ROW1:    cfg_d.mat[1]  = pwdata[47:0];
        REG_ROW2:    cfg_d.mat[2]  = pwdata[47:0];
        REG_AMBIENT: cfg_d.ambient = pwdata[47:0];
        REG_ACTIVE:  cfg_d.active  = pwdata[3:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  // Hold registers, identity matrix after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mat[0]  <= 48'd16384;
      cfg_q.mat[1]  <= 48'd1073741824;
      cfg_q.mat[2]  <= 48'd70368744177664;
      cfg_q.ambient <= '0;
      cfg_q.active  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_ROW0:    prdata = {16'd0, cfg_q.mat[0]};
      REG_ROW1:    prdata = {16'd0, cfg_q.mat[1]};
      REG_ROW2:    prdata = {16'd0, cfg_q.mat[2]};
      REG_AMBIENT: prdata = {16'd0, cfg_q.ambient};
      REG_ACTIVE:  prdata = {60'd0, cfg_q.active};
      default:     prdata = '0;
    endcase
  end

endmodule

@@ rtl/dlvs_ctrl.sv @@
// Sequencer that steps the shared multiplier, root and divider per shade request.
module dlvs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic           action_i,
  input  logic [3:0]     active_i,
  input  dlvs_pkg::stat_t stat_i,
  output dlvs_pkg::cmd_t  cmd_o,
  output logic           in_ready_o
);
  import dlvs_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_MAT    = 11'b000_0000_0010,
    ST_LEN    = 11'b000_0000_0100,
    ST_CHK    = 11'b000_0000_1000,
    ST_SQRT   = 11'b000_0001_0000,
    ST_DIVI   = 11'b000_0010_0000,
    ST_DIVS   = 11'b000_0100_0000,
    ST_LSTART = 11'b000_1000_0000,
    ST_LDOT   = 11'b001_0000_0000,
    ST_LCOL   = 11'b010_0000_0000,
    ST_LNEXT  = 11'b100_0000_0000
  } state_e;

  state_e           st_q, st_d;
  logic             ph_q, ph_d;
  logic [1:0]       row_q, row_d, col_q, col_d;
  logic [4:0]       step_q, step_d;
  logic [CNT_W-1:0] lt_q, lt_d, count;
  logic             done_q, done_d;

  // Clamp the light count
  always_comb begin
    if (32'(active_i) > MAX_LIGHTS) count = CNT_W'(MAX_LIGHTS);
    else count = CNT_W'(active_i);
  end

  always_comb begin
    st_d   = st_q;
    ph_d   = ph_q;
    row_d  = row_q;
    col_d  = col_q;
    step_d = step_q;
    lt_d   = lt_q;
    done_d = done_q;
    cmd_o  = '0;
    cmd_o.op    = MOP_MAT;
    cmd_o.row   = row_q;
    cmd_o.col   = col_q;
    cmd_o.step  = step_q;
    cmd_o.light = lt_q[LIGHT_W-1:0];
    in_ready_o  = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (done_q) begin
          // hold the result until the output register frees
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            done_d = 1'b0;
          end
        end else begin
          in_ready_o = 1'b1;
          if (in_fire_i && action_i) begin
            st_d  = ST_MAT;
            ph_d  = 1'b0;
            row_d = 2'd0;
            col_d = 2'd0;
          end
        end
      end
      ST_MAT: begin
        cmd_o.op = MOP_MAT;
        if (!ph_q) begin
          cmd_o.mul_en = 1'b1;
          ph_d = 1'b1;
        end else begin
          cmd_o.acc_en = 1'b1;
          ph_d = 1'b0;
          if (col_q == 2'd2) begin
            col_d = 2'd0;
            if (row_q == 2'd2) st_d = ST_LEN;
            else row_d = row_q + 2'd1;
          end else begin
            col_d = col_q + 2'd1;
          end
        end
      end
      ST_LEN: begin
        cmd_o.op = MOP_SQ;
        if (!ph_q) begin
          cmd_o.mul_en = 1'b1;
          ph_d = 1'b1;
        end else begin
          cmd_o.acc_en = 1'b1;
          ph_d = 1'b0;
          if (col_q == 2'd2) begin
            col_d = 2'd0;
            st_d  = ST_CHK;
          end else begin
            col_d = col_q + 2'd1;
          end
        end
      end
      ST_CHK: begin
        if (stat_i.len_big) begin
          cmd_o.sqrt_init = 1'b1;
          step_d = SQRT_TOP;
          st_d   = ST_SQRT;
        end else begin
          cmd_o.copy_t = 1'b1;
          st_d = ST_LSTART;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (step_q == 5'd0) begin
          col_d = 2'd0;
          st_d  = ST_DIVI;
        end else begin
          step_d = step_q - 5'd1;
        end
      end
      ST_DIVI: begin
        cmd_o.div_init = 1'b1;
        step_d = DIV_TOP;
        st_d   = ST_DIVS;
      end
      ST_DIVS: begin
        cmd_o.div_step = 1'b1;
        if (step_q == 5'd0) begin
          if (col_q == 2'd2) begin
            col_d = 2'd0;
            st_d  = ST_LSTART;
          end else begin
            col_d = col_q + 2'd1;
            st_d  = ST_DIVI;
          end
        end else begin
          step_d = step_q - 5'd1;
        end
      end
      ST_LSTART: begin
        cmd_o.dot_clr = 1'b1;
        lt_d  = '0;
        col_d = 2'd0;
        ph_d  = 1'b0;
        if (count == '0) begin
          done_d = 1'b1;
          st_d   = ST_IDLE;
        end else begin
          st_d = ST_LDOT;
        end
      end
      ST_LDOT: begin
        cmd_o.op = MOP_DOT;
        if (!ph_q) begin
          cmd_o.mul_en = 1'b1;
          ph_d = 1'b1;
        end else begin
          cmd_o.acc_en = 1'b1;
          ph_d = 1'b0;
          if (col_q == 2'd2) begin
            col_d = 2'd0;
            st_d  = ST_LCOL;
          end else begin
            col_d = col_q + 2'd1;
          end
        end
      end
      ST_LCOL: begin
        cmd_o.op = MOP_COL;
        if (!stat_i.dot_pos) begin
          // light faces away: skip its color
          st_d = ST_LNEXT;
        end else if (!ph_q) begin
          cmd_o.mul_en = 1'b1;
          ph_d = 1'b1;
        end else begin
          cmd_o.acc_en = 1'b1;
          ph_d = 1'b0;
          if (col_q == 2'd2) begin
            col_d = 2'd0;
            st_d  = ST_LNEXT;
          end else begin
            col_d = col_q + 2'd1;
          end
        end
      end
      ST_LNEXT: begin
        cmd_o.dot_clr = 1'b1;
        if (lt_q == count - CNT_W'(1)) begin
          done_d = 1'b1;
          st_d   = ST_IDLE;
        end else begin
          lt_d = lt_q + CNT_W'(1);
          st_d = ST_LDOT;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      ph_q   <= 1'b0;
      row_q  <= '0;
      col_q  <= '0;
      step_q <= '0;
      lt_q   <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ph_q   <= ph_d;
      row_q  <= row_d;
      col_q  <= col_d;
      step_q <= step_d;
      lt_q   <= lt_d;
      done_q <= done_d;
    end
  end

endmodule

@@ rtl/dlvs_dp.sv @@
// Datapath: light slots, shared multiplier, root and divider, output register.
module dlvs_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dlvs_pkg::cfg_t        cfg_i,
  input  dlvs_pkg::cmd_t        cmd_i,
  output dlvs_pkg::stat_t       stat_o,
  input  logic                  in_fire_i,
  input  logic                  action_i,
  input  logic signed [7:0]     normal_x_i,
  input  logic signed [7:0]     normal_y_i,
  input  logic signed [7:0]     normal_z_i,
  input  logic                  last_normal_i,
  input  logic [2:0]            light_slot_i,
  input  logic signed [15:0]    light_dir_x_i,
  input  logic signed [15:0]    light_dir_y_i,
  input  logic signed [15:0]    light_dir_z_i,
  input  logic [11:0]           light_red_i,
  input  logic [11:0]           light_green_i,
  input  logic [11:0]           light_blue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           red_o,
  output logic [15:0]           green_o,
  output logic [15:0]           blue_o,
  output logic                  batch_end_o
);
  import dlvs_pkg::*;

  logic [47:0]              dir_q   [MAX_LIGHTS];
  logic [35:0]              color_q [MAX_LIGHTS];
  logic signed [7:0]        n_q     [3];
  logic signed [T_W-1:0]    t_q     [3];
  logic signed [U_W-1:0]    u_q     [3];
  logic [SUM_W-1:0]         sum_q   [3];
  logic [L_W-1:0]           len_q;
  logic [L_W-1:0]           v_q;
  logic [RES_W-1:0]         res_q;
  logic [REM_W-1:0]         rem_q;
  logic [Q_W-1:0]           q_q;
  logic signed [DOT_W-1:0]  dot_q;
  logic signed [P_W-1:0]    prod_q;
  logic                     last_q;
  logic                     out_valid_q;
  logic [15:0]              out_q [3];
  logic                     bend_q;

  logic [7:0]               slot_ext;
  logic [LIGHT_W-1:0]       slot_idx;
  logic signed [M_W-1:0]    op_a, op_b;
  logic [RES_W-1:0]         sq_bit, sq_trial;
  logic [R_W-1:0]           root;
  logic [T_W-1:0]           mag;
  logic                     div_ge;
  logic [REM_W-1:0]         rem_diff;
  logic [Q_W-1:0]           q_next, q_clamp;
  logic [47:0]              cur_dir;
  logic [35:0]              cur_color;

  assign slot_ext  = {5'd0, light_slot_i};
  assign slot_idx  = slot_ext[LIGHT_W-1:0];
  assign cur_dir   = dir_q[cmd_i.light];
  assign cur_color = color_q[cmd_i.light];

  // Write a light slot on a load request
  always_ff @(posedge clk_i) begin
    if (in_fire_i && !action_i && (32'(light_slot_i) < MAX_LIGHTS)) begin
      dir_q[slot_idx]   <= {light_dir_z_i, light_dir_y_i, light_dir_x_i};
      color_q[slot_idx] <= {light_blue_i, light_green_i, light_red_i};
    end
  end

  // Select multiplier operands
  always_comb begin
    case (cmd_i.op)
      MOP_MAT: begin
        op_a = M_W'($signed(cfg_i.mat[cmd_i.row][16*cmd_i.col +: 16]));
        op_b = M_W'(n_q[cmd_i.row]);
      end
      MOP_SQ: begin
        op_a = M_W'(t_q[cmd_i.col]);
        op_b = M_W'(t_q[cmd_i.col]);
      end
      MOP_DOT: begin
        op_a = M_W'(u_q[cmd_i.col]);
        op_b = M_W'($signed(cur_dir[16*cmd_i.col +: 16]));
      end
      MOP_COL: begin
        op_a = $signed({20'd0, cur_color[12*cmd_i.col +: 12]});
        op_b = dot_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Root step: one result bit per cycle
  assign sq_bit   = RES_W'(1) << {cmd_i.step, 1'b0};
  assign sq_trial = res_q + sq_bit;
  assign root     = res_q[R_W-1:0];

  // Divider step: one quotient bit per cycle
  assign mag      = t_q[cmd_i.col][T_W-1] ? T_W'(-t_q[cmd_i.col]) : T_W'(t_q[cmd_i.col]);
  assign div_ge   = rem_q >= {1'b0, root};
  assign rem_diff = div_ge ? (rem_q - {1'b0, root}) : rem_q;
  assign q_next   = {q_q[Q_W-2:0], div_ge};
  assign q_clamp  = (q_next > ONE_Q14) ? ONE_Q14 : q_next;

  always_ff @(posedge clk_i) begin
    // latch the normal, clear the length and transform sums, preset colors to ambient on a shade request
    if (in_fire_i && action_i) begin
      n_q[0] <= normal_x_i;
      n_q[1] <= normal_y_i;
      n_q[2] <= normal_z_i;
      last_q <= last_normal_i;
      len_q  <= '0;
      for (int j = 0; j < 3; j++) begin
        t_q[j]   <= '0;
        sum_q[j] <= SUM_W'({cfg_i.ambient[16*j +: 16], 28'd0});
      end
    end
    if (cmd_i.mul_en) prod_q <= op_a * op_b;
    if (cmd_i.acc_en) begin
      case (cmd_i.op)
        MOP_MAT: t_q[cmd_i.col]   <= t_q[cmd_i.col] + prod_q[T_W-1:0];
        MOP_SQ:  len_q            <= len_q + prod_q[L_W-1:0];
        MOP_DOT: dot_q            <= dot_q + prod_q[DOT_W-1:0];
        MOP_COL: sum_q[cmd_i.col] <= sum_q[cmd_i.col] + prod_q[SUM_W-1:0];
        default: dot_q            <= dot_q;
      endcase
    end
    if (cmd_i.dot_clr) dot_q <= '0;
    // short normal: keep it unscaled
    if (cmd_i.copy_t) begin
      for (int j = 0; j < 3; j++) u_q[j] <= t_q[j][U_W-1:0];
    end
    if (cmd_i.sqrt_init) begin
      v_q   <= len_q;
      res_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      if ({1'b0, v_q} >= sq_trial) begin
        v_q   <= v_q - sq_trial[L_W-1:0];
        res_q <= (res_q >> 1) + sq_bit;
      end else begin
        res_q <= res_q >> 1;
      end
    end
    if (cmd_i.div_init) begin
      rem_q <= {1'b0, mag};
      q_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= {rem_diff[REM_W-2:0], 1'b0};
      q_q   <= q_next;
      if (cmd_i.step == 5'd0) begin
        u_q[cmd_i.col] <= t_q[cmd_i.col][T_W-1] ? -$signed({1'b0, q_clamp})
                                               :  $signed({1'b0, q_clamp});
      end
    end
    // saturate into the output register
    if (cmd_i.out_load) begin
      for (int j = 0; j < 3; j++) begin
        out_q[j] <= (sum_q[j][SUM_W-1:44] != '0) ? 16'hFFFF : sum_q[j][43:28];
      end
      bend_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.len_big  = len_q > LEN_SQ_MIN;
  assign stat_o.dot_pos  = dot_q > 0;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign red_o       = out_q[0];
  assign green_o     = out_q[1];
  assign blue_o      = out_q[2];
  assign batch_end_o = bend_q;

endmodule

@@ rtl/dlvs_checker.sv @@
// Port-level checks of the shader, bound to the top level.
`include "assert_macros.svh"
module dlvs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [5:0]  paddr,
  input logic [63:0] prdata,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        action_i,
  input logic        out_valid_o,
  input logic        out_ready_i
);
  import dlvs_pkg::*;

  // a pending result stays offered until taken
  `DLVS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  // a shade request keeps the input closed for at least the next cycle
  `DLVS_ASSERT_NEXT(a_shade_busy, in_valid_i && in_ready_o && action_i, !in_ready_o)
  // a load request never raises a result
  `DLVS_ASSERT_NEXT(a_load_silent, in_valid_i && in_ready_o && !action_i && !out_valid_o,
                    !out_valid_o)
  // the light count reads back as four bits
  `DLVS_ASSERT_NOW(a_active_rd, paddr[5:3] == REG_ACTIVE, prdata[63:4] == 60'd0)

endmodule

bind directional_light_vertex_shade dlvs_checker u_dlvs_checker (.*);

@@ test/directional_light_vertex_shade_tb.sv @@
// Testbench for the directional light vertex shader: self-predicting checks of shaded colors.
`timescale 1ns / 1ps

module directional_light_vertex_shade_tb;
  import dlvs_pkg::*;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        batch_end;
  } color_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [5:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               action_i;
  logic signed [7:0]  normal_x_i;
  logic signed [7:0]  normal_y_i;
  logic signed [7:0]  normal_z_i;
  logic               last_normal_i;
  logic [2:0]         light_slot_i;
  logic signed [15:0] light_dir_x_i;
  logic signed [15:0] light_dir_y_i;
  logic signed [15:0] light_dir_z_i;
  logic [11:0]        light_red_i;
  logic [11:0]        light_green_i;
  logic [11:0]        light_blue_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [15:0]        red_o;
  logic [15:0]        green_o;
  logic [15:0]        blue_o;
  logic               batch_end_o;

  localparam int CYCLE_LIMIT = 1500000;

  // Shadow of the registers and light slots
  logic [47:0] mat_row[3];
  logic [47:0] ambient;
  logic [3:0]  active;
  logic [47:0] slot_dir[MAX_LIGHTS];
  logic [35:0] slot_color[MAX_LIGHTS];
  bit          slot_loaded[MAX_LIGHTS];

  color_t      color_q[$];
  int          errors;
  int          cycles;
  bit          hold_off;
  bit          rx_random;

  directional_light_vertex_shade dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // Compute the lit color of one normal from the shadow state
  function automatic color_t shade_color(logic signed [7:0] nx, logic signed [7:0] ny,
                                         logic signed [7:0] nz, logic last_n);
    longint t[3];
    longint u[3];
    longint n[3];
    longint unsigned sum[3];
    longint unsigned len_sq;
    longint unsigned root;
    longint unsigned mag;
    longint unsigned q;
    longint dp;
    longint unsigned v;
    int cnt;
    color_t c;
    n[0] = nx;
    n[1] = ny;
    n[2] = nz;
    len_sq = 0;
    for (int j = 0; j < 3; j++) begin
      t[j] = 0;
      for (int i = 0; i < 3; i++)
        t[j] += longint'($signed(mat_row[i][16*j +: 16])) * n[i];
      mag = (t[j] < 0) ? -t[j] : t[j];
      len_sq += mag * mag;
    end
    if (len_sq > 268) begin
      root = int_sqrt(len_sq);
      for (int j = 0; j < 3; j++) begin
        mag = (t[j] < 0) ? -t[j] : t[j];
        q = (mag << 14) / root;
        if (q > 16384) q = 16384;
        u[j] = (t[j] < 0) ? -longint'(q) : longint'(q);
      end
    end else begin
      for (int j = 0; j < 3; j++) u[j] = t[j];
    end
    for (int j = 0; j < 3; j++) sum[j] = longint'(ambient[16*j +: 16]) << 28;
    cnt = (active > MAX_LIGHTS) ? MAX_LIGHTS : active;
    for (int k = 0; k < cnt; k++) begin
      dp = 0;
      for (int j = 0; j < 3; j++)
        dp += u[j] * longint'($signed(slot_dir[k][16*j +: 16]));
      if (dp > 0)
        for (int j = 0; j < 3; j++) sum[j] += longint'(slot_color[k][12*j +: 12]) * dp;
    end
    for (int j = 0; j < 3; j++) begin
      v = sum[j] >> 28;
      if (v > 65535) v = 65535;
      if (j == 0) c.red = v[15:0];
      else if (j == 1) c.green = v[15:0];
      else c.blue = v[15:0];
    end
    c.batch_end = last_n;
    return c;
  endfunction

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    color_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (color_q.size() == 0) begin
        $display("%0t unexpected result r=%h g=%h b=%h", $time, red_o, green_o, blue_o);
        errors++;
      end else begin
        e = color_q.pop_front();
        if (red_o !== e.red) begin
          $display("%0t red exp %h got %h", $time, e.red, red_o);
          errors++;
        end
        if (green_o !== e.green) begin
          $display("%0t green exp %h got %h", $time, e.green, green_o);
          errors++;
        end
        if (blue_o !== e.blue) begin
          $display("%0t blue exp %h got %h", $time, e.blue, blue_o);
          errors++;
        end
        if (batch_end_o !== e.batch_end) begin
          $display("%0t batch_end exp %b got %b", $time, e.batch_end, batch_end_o);
          errors++;
        end
      end
    end
  end

  // Drive the receiver's ready with random stalls, or hold it off entirely
  initial begin
    int w;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      w = rx_random ? $urandom_range(0, 15) : 0;
      if (hold_off || w != 0) begin
        out_ready_i <= 1'b0;
        while (hold_off) @(posedge clk_i);
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Send one request and update the prediction when it is taken
  task automatic send_request(logic act, logic signed [7:0] nx, logic signed [7:0] ny,
                              logic signed [7:0] nz, logic last_n, logic [2:0] slot,
                              logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                              logic [11:0] cr, logic [11:0] cg, logic [11:0] cb,
                              bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 15) : 0;
    if (w != 0) begin
      in_valid_i <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    normal_x_i    <= nx;
    normal_y_i    <= ny;
    normal_z_i    <= nz;
    last_normal_i <= last_n;
    light_slot_i  <= slot;
    light_dir_x_i <= dx;
    light_dir_y_i <= dy;
    light_dir_z_i <= dz;
    light_red_i   <= cr;
    light_green_i <= cg;
    light_blue_i  <= cb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (act) begin
      color_q.push_back(shade_color(nx, ny, nz, last_n));
    end else if (slot < MAX_LIGHTS) begin
      slot_dir[slot]    = {dz, dy, dx};
      slot_color[slot]  = {cb, cg, cr};
      slot_loaded[slot] = 1'b1;
    end
  endtask

  task automatic shade(logic signed [7:0] nx, logic signed [7:0] ny, logic signed [7:0] nz,
                       logic last_n, bit gaps);
    send_request(1'b1, nx, ny, nz, last_n, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, gaps);
  endtask

  task automatic load_light(logic [2:0] slot, logic [15:0] dx, logic [15:0] dy,
                            logic [15:0] dz, logic [11:0] cr, logic [11:0] cg,
                            logic [11:0] cb, bit gaps);
    send_request(1'b0, $urandom, $urandom, $urandom, $urandom, slot, dx, dy, dz,
                 cr, cg, cb, gaps);
  endtask

  function automatic logic [15:0] rand_dir();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic load_random_light(logic [2:0] slot, bit gaps);
    load_light(slot, rand_dir(), rand_dir(), rand_dir(), $urandom, $urandom, $urandom, gaps);
  endtask

  // Drop the request, then wait until every result has come, plus the worst shade latency
  task automatic drain();
    in_valid_i <= 1'b0;
    while (color_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    in_valid_i <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(8 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROW0:    mat_row[0] = value[47:0];
      REG_ROW1:    mat_row[1] = value[47:0];
      REG_ROW2:    mat_row[2] = value[47:0];
      REG_AMBIENT: ambient = value[47:0];
      REG_ACTIVE:  active = value[3:0];
      default: ;
    endcase
    // idle between transfers
    @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_row(int mag);
    logic [47:0] r;
    for (int j = 0; j < 3; j++) r[16*j +: 16] = 16'($signed($urandom_range(0, 2*mag)) - mag);
    return r;
  endfunction

  // Extremes of fields, tiny normals, slot and count corner cases
  task automatic test_directed();
    for (int s = 0; s < 8; s++)
      load_light(s[2:0], 16'sd16384, 16'sd0, 16'sd0, 12'hfff, 12'h800, 12'h001, 1'b0);
    load_light(3'd1, -16'sd16384, 16'sd16384, -16'sd16384, 12'h000, 12'hfff, 12'h555, 1'b0);
    load_light(3'd2, 16'sd0, 16'sd0, 16'sd16384, 12'haaa, 12'h000, 12'hfff, 1'b0);
    write_reg(REG_ACTIVE, 64'd3);
    shade(8'sd127, 8'sd127, 8'sd127, 1'b0, 1'b0);
    shade(-8'sd128, -8'sd128, -8'sd128, 1'b1, 1'b0);
    shade(8'sd0, 8'sd0, 8'sd0, 1'b0, 1'b0);
    shade(8'sd1, 8'sd0, 8'sd0, 1'b1, 1'b0);
    shade(8'sd1, -8'sd1, 8'sd0, 1'b0, 1'b0);
    shade(8'sd0, 8'sd0, -8'sd1, 1'b0, 1'b0);
    shade(8'sd127, -8'sd128, 8'sd0, 1'b1, 1'b0);
    drain();
    write_reg(REG_ACTIVE, 64'd15);
    write_reg(REG_AMBIENT, 64'hffff_ffff_ffff);
    shade(8'sd127, 8'sd0, 8'sd0, 1'b1, 1'b0);
    shade(8'sd5, 8'sd3, -8'sd2, 1'b0, 1'b0);
    drain();
    write_reg(REG_AMBIENT, 64'h0000_8000_1000);
    write_reg(REG_ROW0, 48'h8000_8000_8000);
    write_reg(REG_ROW1, 48'h7fff_7fff_7fff);
    write_reg(REG_ROW2, 48'h0000_ffff_0001);
    shade(8'sd127, -8'sd128, 8'sd127, 1'b0, 1'b0);
    shade(-8'sd128, 8'sd127, -8'sd1, 1'b1, 1'b0);
    shade(8'sd0, 8'sd0, 8'sd1, 1'b0, 1'b0);
    drain();
    write_reg(REG_ACTIVE, 64'd0);
    shade(8'sd64, 8'sd64, 8'sd64, 1'b1, 1'b0);
    drain();
  endtask

  // Random matrix, ambient and light count, then a mix of loads and shades
  task automatic test_random(int n_items, bit gaps);
    int mag;
    mag = ($urandom_range(0, 3) == 0) ? 32768 : 20000;
    write_reg(REG_ROW0, rand_row(mag));
    write_reg(REG_ROW1, rand_row(mag));
    write_reg(REG_ROW2, rand_row(mag));
    write_reg(REG_AMBIENT, {$urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4096)),
                            16'($urandom_range(0, 8192)), 16'($urandom_range(0, 8192))});
    write_reg(REG_ACTIVE, $urandom_range(0, 15));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 5) == 0)
        load_random_light(3'($urandom), gaps);
      else
        shade($urandom, $urandom, ($urandom_range(0, 9) == 0) ? 8'sd0 : 8'($urandom),
              $urandom_range(0, 1), gaps);
    end
    drain();
  endtask

  // Hold the receiver off so the block fills and stalls its input
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 12; i++) shade($urandom, $urandom, $urandom, i == 11, 1'b0);
    drain();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    rx_random = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    normal_x_i = '0;
    normal_y_i = '0;
    normal_z_i = '0;
    last_normal_i = 1'b0;
    light_slot_i = '0;
    light_dir_x_i = '0;
    light_dir_y_i = '0;
    light_dir_z_i = '0;
    light_red_i = '0;
    light_green_i = '0;
    light_blue_i = '0;
    mat_row[0] = 48'd16384;
    mat_row[1] = 48'd16384 << 16;
    mat_row[2] = 48'd16384 << 32;
    ambient = '0;
    active = '0;
    for (int s = 0; s < MAX_LIGHTS; s++) slot_loaded[s] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset identity matrix with no lights
    shade(8'sd100, -8'sd50, 8'sd7, 1'b1, 1'b0);
    drain();
    test_directed();
    rx_random = 1'b1;
    for (int p = 0; p < 10; p++) test_random(130, p != 3);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
